### src/swrm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrm_pkg
// Shared types and constants for the stack with remove-maximum.
// ----------------------------------------------------------------------------
package swrm_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned OP_W   = 2;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned HELD_W = 8;

  // Value returned on pop or remove-max of an empty stack
  localparam logic signed [DATA_W-1:0] NEG_ONE = '1;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH       = 2'd0,
    OP_POP        = 2'd1,
    OP_REMOVE_MAX = 2'd2
  } opcode_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_SHIFT,
    S_RESP
  } fsm_e;

endpackage

### src/swrm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrm_in_if / swrm_out_if
// Valid/ready channels for operation items and result items.
// ----------------------------------------------------------------------------
interface swrm_in_if;
  logic                                    valid;
  logic                                    ready;
  logic [swrm_pkg::OP_W-1:0]               opcode;
  logic signed [swrm_pkg::DATA_W-1:0]      push_value;

  modport source (output valid, output opcode, output push_value, input ready);
  modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

interface swrm_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [swrm_pkg::DATA_W-1:0]      result_value;
  logic [swrm_pkg::ST_W-1:0]               status;
  logic [swrm_pkg::HELD_W-1:0]             entries_held;

  modport source (output valid, output result_value, output status, output entries_held,
                  input ready);
  modport sink   (input valid, input result_value, input status, input entries_held,
                  output ready);
endinterface

### src/stack_with_remove_max.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_with_remove_max
// Bounded stack of signed 32-bit values with push, pop and remove-maximum.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one operation per item (opcode, push_value); out_o returns
//   exactly one result item per operation (result_value, status,
//   entries_held), both valid/ready.
//   Push and pop finish in the execute state after accept: the top entry is
//   read from the storage RAM while idle and used in the next cycle.
//   Remove-maximum with n entries and the maximum at slot p scans all n
//   entries down from the top with one RAM read per cycle, then closes the
//   gap with one read/write pair per cycle through the single RAM port pair.
//   One operation is worked on at a time; the next is accepted as soon as
//   the previous result sits in the output register, even if it is stalled.
//   If the receiver stalls and the output register is full, a finished
//   result waits in a holding register and no new item is accepted.
//   Reset empties the stack (fill count zero); the RAM is not cleared and
//   needs no clearing pass.
// ----------------------------------------------------------------------------
module stack_with_remove_max #(
  parameter int unsigned DEPTH = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  swrm_in_if.sink    in_i,
  swrm_out_if.source out_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic                               mem_we;
  logic [AW-1:0]                      mem_waddr;
  logic signed [swrm_pkg::DATA_W-1:0] mem_wdata;
  logic [AW-1:0]                      mem_raddr;
  logic signed [swrm_pkg::DATA_W-1:0] mem_rdata;

  swrm_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  swrm_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

### src/swrm_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrm_mem
// Simple dual-port stack storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module swrm_mem #(
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic                               clk_i,
  input  logic                               we_i,
  input  logic [AW-1:0]                      waddr_i,
  input  logic signed [swrm_pkg::DATA_W-1:0] wdata_i,
  input  logic [AW-1:0]                      raddr_i,
  output logic signed [swrm_pkg::DATA_W-1:0] rdata_o
);

  logic signed [swrm_pkg::DATA_W-1:0] mem [DEPTH];
  logic signed [swrm_pkg::DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/swrm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrm_ctrl
// Sequencer: fill count, push/pop access, max scan and gap-closing shift,
// plus the output register.
// ----------------------------------------------------------------------------
module swrm_ctrl #(
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW   = $clog2(DEPTH),
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  swrm_in_if.sink                            in_i,
  swrm_out_if.source                         out_o,
  output logic                               mem_we_o,
  output logic [AW-1:0]                      mem_waddr_o,
  output logic signed [swrm_pkg::DATA_W-1:0] mem_wdata_o,
  output logic [AW-1:0]                      mem_raddr_o,
  input  logic signed [swrm_pkg::DATA_W-1:0] mem_rdata_i
);

  swrm_pkg::fsm_e state_q, state_d;

  logic [swrm_pkg::OP_W-1:0]            op_q, op_d;
  logic signed [swrm_pkg::DATA_W-1:0]   val_q, val_d;
  logic [CW-1:0]                        cnt_q, cnt_d;
  logic [CW-1:0]                        ptr_q, ptr_d;
  logic signed [swrm_pkg::DATA_W-1:0]   best_q, best_d;
  logic [AW-1:0]                        pos_q, pos_d;
  logic                                 wpend_q, wpend_d;
  logic [AW-1:0]                        waddr_q, waddr_d;

  // Held result when the output register is still occupied
  logic signed [swrm_pkg::DATA_W-1:0]   res_val_q, res_val_d;
  logic [swrm_pkg::ST_W-1:0]            res_st_q, res_st_d;
  logic [swrm_pkg::HELD_W-1:0]          res_held_q, res_held_d;

  logic                                 out_valid_q, out_valid_d;
  logic signed [swrm_pkg::DATA_W-1:0]   out_val_q, out_val_d;
  logic [swrm_pkg::ST_W-1:0]            out_st_q, out_st_d;
  logic [swrm_pkg::HELD_W-1:0]          out_held_q, out_held_d;

  logic                                 fin;
  logic signed [swrm_pkg::DATA_W-1:0]   fin_val;
  logic [swrm_pkg::ST_W-1:0]            fin_st;
  logic                                 out_free;
  logic                                 cnt_empty;
  logic                                 cnt_full;
  logic [AW-1:0]                        pos_next;

  assign out_free  = !out_valid_q || out_o.ready;
  assign cnt_empty = (cnt_q == '0);
  assign cnt_full  = (cnt_q == CW'(DEPTH));
  assign in_i.ready = (state_q == swrm_pkg::S_IDLE);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    val_d       = val_q;
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    best_d      = best_q;
    pos_d       = pos_q;
    wpend_d     = wpend_q;
    waddr_d     = waddr_q;
    fin         = 1'b0;
    fin_val     = '0;
    fin_st      = swrm_pkg::ST_OK;
    pos_next    = pos_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = cnt_q[AW-1:0];
    mem_wdata_o = val_q;
    mem_raddr_o = AW'(cnt_q - 1'b1);

    case (state_q)
      swrm_pkg::S_IDLE: begin
        // Top entry is read speculatively on every idle cycle
        if (in_i.valid) begin
          op_d    = in_i.opcode;
          val_d   = in_i.push_value;
          ptr_d   = cnt_q - 1'b1;
          state_d = swrm_pkg::S_EXEC;
        end
      end

      swrm_pkg::S_EXEC: begin
        case (op_q)
          swrm_pkg::OP_PUSH: begin
            fin = 1'b1;
            if (cnt_full) begin
              fin_st = swrm_pkg::ST_FULL;
            end else begin
              mem_we_o = 1'b1;
              cnt_d    = cnt_q + 1'b1;
            end
          end
          swrm_pkg::OP_POP: begin
            fin = 1'b1;
            if (cnt_empty) begin
              fin_val = swrm_pkg::NEG_ONE;
              fin_st  = swrm_pkg::ST_EMPTY;
            end else begin
              fin_val = mem_rdata_i;
              cnt_d   = cnt_q - 1'b1;
            end
          end
          swrm_pkg::OP_REMOVE_MAX: begin
            if (cnt_empty) begin
              fin     = 1'b1;
              fin_val = swrm_pkg::NEG_ONE;
              fin_st  = swrm_pkg::ST_EMPTY;
            end else begin
              best_d = mem_rdata_i;
              pos_d  = ptr_q[AW-1:0];
              if (ptr_q == '0) begin
                ptr_d   = ptr_q + 1'b1;
                wpend_d = 1'b0;
                state_d = swrm_pkg::S_SHIFT;
              end else begin
                mem_raddr_o = AW'(ptr_q - 1'b1);
                ptr_d       = ptr_q - 1'b1;
                state_d     = swrm_pkg::S_SCAN;
              end
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end

      // Data of entry ptr_q arrives; strict compare keeps the topmost copy
      swrm_pkg::S_SCAN: begin
        if (mem_rdata_i > best_q) begin
          best_d   = mem_rdata_i;
          pos_next = ptr_q[AW-1:0];
        end
        pos_d = pos_next;
        if (ptr_q == '0) begin
          ptr_d   = CW'(pos_next) + 1'b1;
          wpend_d = 1'b0;
          state_d = swrm_pkg::S_SHIFT;
        end else begin
          mem_raddr_o = AW'(ptr_q - 1'b1);
          ptr_d       = ptr_q - 1'b1;
        end
      end

      // Read entry ptr_q, write it one slot lower in the next cycle
      swrm_pkg::S_SHIFT: begin
        mem_we_o    = wpend_q;
        mem_waddr_o = waddr_q;
        mem_wdata_o = mem_rdata_i;
        if (ptr_q < cnt_q) begin
          mem_raddr_o = ptr_q[AW-1:0];
          waddr_d     = AW'(ptr_q - 1'b1);
          wpend_d     = 1'b1;
          ptr_d       = ptr_q + 1'b1;
        end else begin
          wpend_d = 1'b0;
          if (!wpend_q) begin
            fin     = 1'b1;
            fin_val = best_q;
            cnt_d   = cnt_q - 1'b1;
          end
        end
      end

      swrm_pkg::S_RESP: begin
        if (out_free) begin
          state_d = swrm_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = swrm_pkg::S_IDLE;
      end
    endcase

    if (fin) begin
      state_d = out_free ? swrm_pkg::S_IDLE : swrm_pkg::S_RESP;
    end
  end

  // Output register and result holding stage
  always_comb begin
    res_val_d   = res_val_q;
    res_st_d    = res_st_q;
    res_held_d  = res_held_q;
    out_valid_d = out_valid_q;
    out_val_d   = out_val_q;
    out_st_d    = out_st_q;
    out_held_d  = out_held_q;

    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end

    if (fin) begin
      res_val_d  = fin_val;
      res_st_d   = fin_st;
      res_held_d = swrm_pkg::HELD_W'(cnt_d);
    end

    if (fin && out_free) begin
      out_valid_d = 1'b1;
      out_val_d   = fin_val;
      out_st_d    = fin_st;
      out_held_d  = swrm_pkg::HELD_W'(cnt_d);
    end else if (state_q == swrm_pkg::S_RESP && out_free) begin
      out_valid_d = 1'b1;
      out_val_d   = res_val_q;
      out_st_d    = res_st_q;
      out_held_d  = res_held_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swrm_pkg::S_IDLE;
      cnt_q       <= '0;
      wpend_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      wpend_q     <= wpend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    val_q      <= val_d;
    ptr_q      <= ptr_d;
    best_q     <= best_d;
    pos_q      <= pos_d;
    waddr_q    <= waddr_d;
    res_val_q  <= res_val_d;
    res_st_q   <= res_st_d;
    res_held_q <= res_held_d;
    out_val_q  <= out_val_d;
    out_st_q   <= out_st_d;
    out_held_q <= out_held_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.result_value = out_val_q;
  assign out_o.status       = out_st_q;
  assign out_o.entries_held = out_held_q;

endmodule

### src/swrm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrm_checker
// Port-level checks on the result channel of the stack.
// ----------------------------------------------------------------------------
module swrm_checker #(
  parameter int unsigned DEPTH = 128
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               out_valid_i,
  input logic                               out_ready_i,
  input logic signed [swrm_pkg::DATA_W-1:0] result_value_i,
  input logic [swrm_pkg::ST_W-1:0]          status_i,
  input logic [swrm_pkg::HELD_W-1:0]        entries_held_i
);

  logic [swrm_pkg::HELD_W-1:0] prev_held_q;
  logic                        seen_q;
  logic [swrm_pkg::HELD_W-1:0] held_step;
  logic                        out_fire;

  assign out_fire  = out_valid_i && out_ready_i;
  assign held_step = entries_held_i - prev_held_q;

  // Last delivered fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= 1'b0;
      prev_held_q <= '0;
    end else if (out_fire) begin
      seen_q      <= 1'b1;
      prev_held_q <= entries_held_i;
    end
  end

  // A stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(result_value_i)
      && $stable(status_i) && $stable(entries_held_i))
    else $error("result item changed while stalled");

  // Full is only reported with the stack at capacity
  a_full_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == swrm_pkg::ST_FULL |->
      entries_held_i == swrm_pkg::HELD_W'(DEPTH) && result_value_i == '0)
    else $error("full status with wrong level or value");

  // Empty result carries -1 and a zero level
  a_empty_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == swrm_pkg::ST_EMPTY |->
      result_value_i == swrm_pkg::NEG_ONE && entries_held_i == '0)
    else $error("empty status with wrong value or level");

  // Each operation moves the level by at most one entry
  a_level_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && seen_q |->
      held_step == '0 || held_step == swrm_pkg::HELD_W'(1) || held_step == '1)
    else $error("fill level jumped by more than one entry");

endmodule

bind stack_with_remove_max swrm_checker #(
  .DEPTH (DEPTH)
) u_swrm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .result_value_i (out_o.result_value),
  .status_i       (out_o.status),
  .entries_held_i (out_o.entries_held)
);

### tb/tb_stack_with_remove_max.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stack_with_remove_max
// Self-checking bench for the bounded stack with push, pop and remove-max.
// Operations go in on the op channel and the bench mirrors the stack, so
// every result item (value, status, fill count) is checked in order against
// the mirror. Covers empty and full edges, ties, signed extremes, long
// output back-pressure and several idle/stall mixes on both channels.
// ----------------------------------------------------------------------------
module tb_stack_with_remove_max;

  localparam int DEPTH     = 128;
  localparam int TAIL_CYC  = 40;
  localparam int HOLD_CYC  = 300;
  localparam int PRINT_MAX = 50;

  typedef struct {
    logic signed [swrm_pkg::DATA_W-1:0] value;
    swrm_pkg::status_e                  st;
    logic [swrm_pkg::HELD_W-1:0]        held;
  } outcome_t;

  logic clk;
  logic rst_n;

  swrm_in_if  op_ch ();
  swrm_out_if res_ch ();

  stack_with_remove_max #(
    .DEPTH (DEPTH)
  ) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (op_ch),
    .out_o  (res_ch)
  );

  // Mirror of the stack contents, bottom at index 0
  logic signed [swrm_pkg::DATA_W-1:0] stack_mirror [DEPTH];
  int                                 stack_fill;
  outcome_t                           expected_q [$];

  // Channel behavior knobs
  int source_idle_pct;
  int sink_stall_pct;
  int hold_request = 0;  // bumped by a test to ask for one long hold-off
  int hold_seen    = 0;
  int hold_left    = 0;

  // Bookkeeping
  int error_count;
  int results_checked;
  int push_count;
  int pop_count;
  int remove_max_count;
  int full_refusals;
  int empty_answers;
  int deepest_fill;
  int input_stall_cycles;

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit
  initial begin
    #4_000_000;
    $display("Timeout with %0d results still outstanding", expected_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic report_mismatch(string what, longint want, longint got);
    error_count++;
    if (error_count <= PRINT_MAX) begin
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  // Apply one operation to the mirror and queue the result it must produce
  function automatic void predict_op(swrm_pkg::opcode_e op,
                                     logic signed [swrm_pkg::DATA_W-1:0] val);
    outcome_t r;
    int       best;
    r.value = '0;
    r.st    = swrm_pkg::ST_OK;
    case (op)
      swrm_pkg::OP_PUSH: begin
        push_count++;
        if (stack_fill >= DEPTH) begin
          r.st = swrm_pkg::ST_FULL;
          full_refusals++;
        end else begin
          stack_mirror[stack_fill] = val;
          stack_fill++;
        end
      end
      swrm_pkg::OP_POP: begin
        pop_count++;
        if (stack_fill == 0) begin
          r.value = swrm_pkg::NEG_ONE;
          r.st    = swrm_pkg::ST_EMPTY;
          empty_answers++;
        end else begin
          stack_fill--;
          r.value = stack_mirror[stack_fill];
        end
      end
      swrm_pkg::OP_REMOVE_MAX: begin
        remove_max_count++;
        if (stack_fill == 0) begin
          r.value = swrm_pkg::NEG_ONE;
          r.st    = swrm_pkg::ST_EMPTY;
          empty_answers++;
        end else begin
          // scan down from the top; strict compare keeps the topmost copy
          best = stack_fill - 1;
          for (int k = stack_fill - 2; k >= 0; k--) begin
            if (stack_mirror[k] > stack_mirror[best]) best = k;
          end
          r.value = stack_mirror[best];
          for (int k = best; k < stack_fill - 1; k++) begin
            stack_mirror[k] = stack_mirror[k + 1];
          end
          stack_fill--;
        end
      end
      default: ;
    endcase
    if (stack_fill > deepest_fill) deepest_fill = stack_fill;
    r.held = swrm_pkg::HELD_W'(stack_fill);
    expected_q.push_back(r);
  endfunction

  // Offer one item; valid stays up on return so the next call can follow
  // without a gap. Callers that pause must go through stop_sending.
  task automatic send_op(swrm_pkg::opcode_e op, logic signed [swrm_pkg::DATA_W-1:0] val);
    while ($urandom_range(99) < source_idle_pct) begin
      op_ch.valid <= 1'b0;
      @(posedge clk);
    end
    op_ch.valid      <= 1'b1;
    op_ch.opcode     <= op;
    op_ch.push_value <= val;
    do @(posedge clk); while (!op_ch.ready);
    predict_op(op, val);
  endtask

  task automatic stop_sending();
    op_ch.valid <= 1'b0;
  endtask

  task automatic wait_drain();
    stop_sending();
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // Mix of signed extremes, small values that tie often, and anything
  function automatic logic signed [swrm_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2, 3:    return int'($urandom_range(6)) - 3;
      default: return $urandom;
    endcase
  endfunction

  // Output ready: long hold-off on request, otherwise random stalls
  always @(posedge clk) begin : drive_result_ready
    if (hold_left > 0) begin
      hold_left--;
      res_ch.ready <= 1'b0;
    end else if (hold_request != hold_seen) begin
      hold_seen    = hold_request;
      hold_left    = HOLD_CYC - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin : check_results
    outcome_t want;
    if (rst_n) begin
      if (op_ch.valid && !op_ch.ready) input_stall_cycles++;
      if (res_ch.valid && res_ch.ready) begin
        results_checked++;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result item", 0, res_ch.result_value);
        end else begin
          want = expected_q.pop_front();
          if (res_ch.result_value !== want.value)
            report_mismatch("result_value", want.value, res_ch.result_value);
          if (res_ch.status !== want.st)
            report_mismatch("status", want.st, res_ch.status);
          if (res_ch.entries_held !== want.held)
            report_mismatch("entries_held", want.held, res_ch.entries_held);
        end
      end
    end
  end

  // Empty-stack answers, signed extremes, ties and max at top/middle/bottom
  task automatic test_empty_and_extremes();
    send_op(swrm_pkg::OP_POP, $urandom);
    send_op(swrm_pkg::OP_REMOVE_MAX, $urandom);
    send_op(swrm_pkg::OP_PUSH, 32'sh7FFF_FFFF);
    send_op(swrm_pkg::OP_PUSH, 32'sh8000_0000);
    send_op(swrm_pkg::OP_PUSH, 32'sd0);
    send_op(swrm_pkg::OP_PUSH, -32'sd1);
    send_op(swrm_pkg::OP_PUSH, 32'sh7FFF_FFFF);
    send_op(swrm_pkg::OP_PUSH, -32'sd2);
    send_op(swrm_pkg::OP_PUSH, 32'sd1);
    // tie: upper copy of the max leaves, entries above it slide down
    send_op(swrm_pkg::OP_REMOVE_MAX, $urandom);
    send_op(swrm_pkg::OP_POP, $urandom);
    send_op(swrm_pkg::OP_POP, $urandom);
    // max at the bottom: whole stack shifts
    send_op(swrm_pkg::OP_REMOVE_MAX, $urandom);
    send_op(swrm_pkg::OP_REMOVE_MAX, $urandom);
    send_op(swrm_pkg::OP_POP, $urandom);
    // single entry holding the most negative value
    send_op(swrm_pkg::OP_REMOVE_MAX, $urandom);
    send_op(swrm_pkg::OP_POP, $urandom);
    send_op(swrm_pkg::OP_PUSH, -32'sd5);
    send_op(swrm_pkg::OP_PUSH, -32'sd3);
    send_op(swrm_pkg::OP_REMOVE_MAX, $urandom);
    send_op(swrm_pkg::OP_REMOVE_MAX, $urandom);
    send_op(swrm_pkg::OP_REMOVE_MAX, $urandom);
    wait_drain();
  endtask

  // Fill to capacity, push into a full stack, scan a full stack, then drain
  task automatic test_fill_to_capacity();
    while (stack_fill < DEPTH) send_op(swrm_pkg::OP_PUSH, pick_value());
    repeat (3) send_op(swrm_pkg::OP_PUSH, pick_value());
    send_op(swrm_pkg::OP_REMOVE_MAX, $urandom);
    send_op(swrm_pkg::OP_REMOVE_MAX, $urandom);
    send_op(swrm_pkg::OP_PUSH, pick_value());
    send_op(swrm_pkg::OP_PUSH, pick_value());
    send_op(swrm_pkg::OP_PUSH, pick_value());
    while (stack_fill > 0) begin
      if ($urandom_range(1)) send_op(swrm_pkg::OP_POP, $urandom);
      else send_op(swrm_pkg::OP_REMOVE_MAX, $urandom);
    end
    send_op(swrm_pkg::OP_POP, $urandom);
    wait_drain();
  endtask

  // Receiver holds off for a long stretch while items keep coming
  task automatic test_backpressure();
    int roll;
    hold_request++;
    repeat (40) begin
      roll = $urandom_range(99);
      if (roll < 60) send_op(swrm_pkg::OP_PUSH, pick_value());
      else if (roll < 90) send_op(swrm_pkg::OP_POP, $urandom);
      else send_op(swrm_pkg::OP_REMOVE_MAX, $urandom);
    end
    wait_drain();
  endtask

  // Random operations in grow and shrink swings so the fill sweeps the range
  task automatic test_random_ops(int n_items);
    bit growing = 1'b1;
    int roll;
    for (int i = 0; i < n_items; i++) begin
      if (stack_fill >= DEPTH && $urandom_range(3) == 0) growing = 1'b0;
      else if (stack_fill == 0) growing = 1'b1;
      else if ($urandom_range(99) < 2) growing = !growing;
      roll = $urandom_range(99);
      if (roll < (growing ? 75 : 25)) send_op(swrm_pkg::OP_PUSH, pick_value());
      else if ($urandom_range(1)) send_op(swrm_pkg::OP_POP, $urandom);
      else send_op(swrm_pkg::OP_REMOVE_MAX, $urandom);
    end
  endtask

  // Test sequence
  initial begin
    rst_n            = 1'b0;
    op_ch.valid      = 1'b0;
    op_ch.opcode     = swrm_pkg::OP_PUSH;
    op_ch.push_value = '0;
    stack_fill       = 0;
    source_idle_pct  = 0;
    sink_stall_pct   = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_and_extremes();
    test_fill_to_capacity();

    test_random_ops(250);
    source_idle_pct = 51;
    test_random_ops(250);
    source_idle_pct = 0;
    sink_stall_pct  = 51;
    test_random_ops(250);
    source_idle_pct = 10;
    sink_stall_pct  = 10;
    test_random_ops(250);

    wait_drain();
    source_idle_pct = 0;
    sink_stall_pct  = 0;
    test_backpressure();

    wait_drain();
    repeat (TAIL_CYC) @(posedge clk);

    $display("Ran %0d operations (%0d push, %0d pop, %0d remove-max); %0d results checked",
             push_count + pop_count + remove_max_count, push_count, pop_count,
             remove_max_count, results_checked);
    $display("Deepest fill %0d of %0d, %0d full refusals, %0d empty answers, %0d input stalls",
             deepest_fill, DEPTH, full_refusals, empty_answers, input_stall_cycles);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", error_count);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
src/swrm_pkg.sv
src/swrm_if.sv
src/swrm_mem.sv
src/swrm_ctrl.sv
src/stack_with_remove_max.sv
src/swrm_checker.sv
tb/tb_stack_with_remove_max.sv
